FILE: rtl/core/fsq_pkg.sv
// ----------------------------------------------------------------------------
// fsq_pkg
// Shared types, codes and constants of the four-step note sequencer.
// ----------------------------------------------------------------------------
package fsq_pkg;

	localparam int SLOWEST_TICKS = 20;
	localparam int LOWEST_NOTE   = 36;
	localparam int NOTE_SPAN     = 48;
	localparam int LOCKOUT_TICKS = 6;

	localparam int NUM_STEPS   = 4;
	localparam int NUM_BUTTONS = NUM_STEPS + 1;
	localparam int KNOB_W      = 10;
	localparam int NOTE_W      = 7;
	localparam int CNT_W       = 8;
	localparam int LOCK_W      = 4;
	localparam int LED_W       = NUM_STEPS + 1;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);

	// tempo drop divisor and its rounded-up reciprocal over a 24-bit shift
	localparam int TEMPO_DIV0  = 1024 / (SLOWEST_TICKS - 1);
	localparam int TEMPO_DIV   = (TEMPO_DIV0 == 0) ? 1 : TEMPO_DIV0;
	localparam int RECIP_SH    = 24;
	localparam int TEMPO_RECIP = ((1 << RECIP_SH) + TEMPO_DIV - 1) / TEMPO_DIV;
	localparam int PITCH_MUL   = NOTE_SPAN - 11;

	// input commands
	localparam logic [1:0] CMD_TICK        = 2'd0;
	localparam logic [1:0] CMD_START_STOP  = 2'd1;
	localparam logic [1:0] CMD_STEP_TOGGLE = 2'd2;

	// message kinds
	localparam logic [1:0] MSG_NONE = 2'd0;
	localparam logic [1:0] MSG_ON   = 2'd1;
	localparam logic [1:0] MSG_OFF  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PITCH    = 2'd0;
	localparam logic [1:0] CFG_VELOCITY = 2'd1;
	localparam logic [1:0] CFG_LENGTH   = 2'd2;
	localparam logic [1:0] CFG_TEMPO    = 2'd3;

	localparam logic [NUM_STEPS-1:0][3:0] STEP_OFFSET = {4'd11, 4'd7, 4'd4, 4'd0};

	// one classified item, handed from front to back
	typedef struct packed {
		logic [NUM_STEPS-1:0]             off_mask;
		logic                             on_flag;
		logic [NUM_STEPS-1:0][NOTE_W-1:0] off_note;
		logic [NUM_STEPS-1:0][NOTE_W-1:0] off_vel;
		logic [NOTE_W-1:0]                on_note;
		logic [NOTE_W-1:0]                on_vel;
		logic [LED_W-1:0]                 leds;
		logic                             run;
	} rec_t;

endpackage

FILE: rtl/core/fsq_front.sv
// ----------------------------------------------------------------------------
// fsq_front
// Knob registers and sequencer state; classifies each item into one record.
// ----------------------------------------------------------------------------
module fsq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [1:0]         cmd,
	input  logic [1:0]         step_button,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data,
	output fsq_pkg::rec_t      rec
);
	import fsq_pkg::*;

	logic [CNT_W-1:0]  tempo_val_q;
	logic [7:0]        base_q;
	logic [NOTE_W-1:0] vel_q;
	logic [KNOB_W-1:0] length_knob_q;

	logic                             run_q;
	logic [CNT_W-1:0]                 tc_q;
	logic                             used_q;
	logic [1:0]                       ptr_q;
	logic [NUM_STEPS-1:0]             act_q;
	logic [NUM_STEPS-1:0][NOTE_W-1:0] snote_q;
	logic [NUM_STEPS-1:0][NOTE_W-1:0] svel_q;
	logic [NUM_STEPS-1:0]             osent_q;
	logic [NUM_STEPS-1:0][CNT_W-1:0]  offc_q;
	logic [NUM_BUTTONS-1:0][LOCK_W-1:0] lock_q;

	logic                             run_n;
	logic [CNT_W-1:0]                 tc_n;
	logic                             used_n;
	logic [1:0]                       ptr_n;
	logic [NUM_STEPS-1:0]             act_n;
	logic [NUM_STEPS-1:0][NOTE_W-1:0] snote_n;
	logic [NUM_STEPS-1:0][NOTE_W-1:0] svel_n;
	logic [NUM_STEPS-1:0]             osent_n;
	logic [NUM_STEPS-1:0][CNT_W-1:0]  offc_n;
	logic [NUM_BUTTONS-1:0][LOCK_W-1:0] lock_n;

	logic [31:0]       drop_prod;
	logic [CNT_W-1:0]  drop;
	logic [CNT_W-1:0]  tempo_new;
	logic [16:0]       pitch_prod;
	logic [17:0]       len_prod;
	logic [CNT_W-1:0]  len;
	logic [2:0]        bidx;
	logic [NOTE_W-1:0] on_note;

	// knob derivations done at write time
	assign drop_prod  = 32'(cfg_data) * 32'(TEMPO_RECIP);
	assign drop       = CNT_W'(drop_prod >> RECIP_SH);
	assign tempo_new  = (drop >= CNT_W'(SLOWEST_TICKS)) ? '0 : CNT_W'(SLOWEST_TICKS) - drop;
	assign pitch_prod = 17'(cfg_data) * 17'(PITCH_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_val_q   <= CNT_W'(SLOWEST_TICKS);
			base_q        <= 8'(LOWEST_NOTE);
			vel_q         <= '0;
			length_knob_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PITCH:    base_q <= 8'(pitch_prod >> 10) + 8'(LOWEST_NOTE);
				CFG_VELOCITY: vel_q <= cfg_data[9:3];
				CFG_LENGTH:   length_knob_q <= cfg_data;
				CFG_TEMPO:    tempo_val_q <= tempo_new;
				default:      ;
			endcase
		end
	end

	assign len_prod = 18'(length_knob_q) * 18'(tempo_val_q);
	assign len      = CNT_W'((len_prod >> 10) + 18'd1);
	assign bidx     = {1'b0, step_button} + 3'd1;
	assign on_note  = NOTE_W'(base_q + 8'(STEP_OFFSET[ptr_q]));

	always_comb begin
		run_n   = run_q;
		tc_n    = tc_q;
		used_n  = used_q;
		ptr_n   = ptr_q;
		act_n   = act_q;
		snote_n = snote_q;
		svel_n  = svel_q;
		osent_n = osent_q;
		offc_n  = offc_q;
		lock_n  = lock_q;
		rec     = '0;
		rec.off_note = snote_q;
		rec.off_vel  = svel_q;
		rec.on_note  = on_note;
		rec.on_vel   = vel_q;

		case (cmd)
			CMD_TICK: begin
				tc_n   = (tc_q != '0) ? tc_q - 1'b1 : tempo_val_q;
				used_n = 1'b0;
				for (int i = 0; i < NUM_STEPS; i++) begin
					if (offc_q[i] != '0) offc_n[i] = offc_q[i] - 1'b1;
				end
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					if (lock_q[i] != '0) lock_n[i] = lock_q[i] - 1'b1;
				end
			end
			CMD_START_STOP: begin
				if (lock_q[0] == '0) begin
					if (run_q) begin
						run_n        = 1'b0;
						ptr_n        = '0;
						rec.off_mask = '1;
					end else begin
						act_n = '1;
						run_n = 1'b1;
					end
					lock_n[0] = LOCK_W'(LOCKOUT_TICKS);
				end
			end
			CMD_STEP_TOGGLE: begin
				if (run_q && lock_q[bidx] == '0) begin
					act_n[step_button] = ~act_q[step_button];
					lock_n[bidx]       = LOCK_W'(LOCKOUT_TICKS);
				end
			end
			default: ;
		endcase

		if (run_n) begin
			for (int i = 0; i < NUM_STEPS; i++) begin
				if (offc_n[i] == '0 && !osent_q[i]) begin
					rec.off_mask[i] = 1'b1;
					osent_n[i]      = 1'b1;
				end
			end
			if (tc_n == '0 && !used_n) begin
				if (act_n[ptr_q]) begin
					snote_n[ptr_q] = on_note;
					svel_n[ptr_q]  = vel_q;
					offc_n[ptr_q]  = len;
					osent_n[ptr_q] = 1'b0;
					rec.on_flag    = 1'b1;
				end
				used_n = 1'b1;
				ptr_n  = ptr_q + 2'd1;
			end
		end

		rec.run  = run_n;
		rec.leds = run_n ? {act_n, 1'b1} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			tc_q    <= '0;
			used_q  <= 1'b0;
			ptr_q   <= '0;
			act_q   <= '0;
			snote_q <= '0;
			svel_q  <= '0;
			osent_q <= '0;
			offc_q  <= '0;
			lock_q  <= '0;
		end else if (take) begin
			run_q   <= run_n;
			tc_q    <= tc_n;
			used_q  <= used_n;
			ptr_q   <= ptr_n;
			act_q   <= act_n;
			snote_q <= snote_n;
			svel_q  <= svel_n;
			osent_q <= osent_n;
			offc_q  <= offc_n;
			lock_q  <= lock_n;
		end
	end

endmodule

FILE: rtl/core/fsq_queue.sv
// ----------------------------------------------------------------------------
// fsq_queue
// Short record queue between the front and the back.
// ----------------------------------------------------------------------------
module fsq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  fsq_pkg::rec_t wr_rec,
	output logic          q_full,
	input  logic          rd,
	output fsq_pkg::rec_t rd_rec,
	output logic          q_empty
);
	import fsq_pkg::*;

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_rec  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == QPTR_W'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == QPTR_W'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/fsq_back.sv
// ----------------------------------------------------------------------------
// fsq_back
// Drains one record as a series of messages, one per pop.
// ----------------------------------------------------------------------------
module fsq_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fsq_pkg::rec_t q_rec,
	input  logic          q_empty,
	output logic          q_rd,
	output logic          empty,
	input  logic          pop,
	output logic [1:0]    msg_kind,
	output logic [6:0]    note_number,
	output logic [6:0]    note_velocity,
	output logic [4:0]    led_mask,
	output logic          is_running,
	output logic          last_result
);
	import fsq_pkg::*;

	rec_t                 cur_q;
	logic                 valid_q;
	logic [NUM_STEPS:0]   pend_q;
	logic                 none_q;

	logic [NUM_STEPS:0]   low;
	logic [NUM_STEPS:0]   rest;
	logic                 is_last;

	assign low     = pend_q & (~pend_q + 1'b1);
	assign rest    = pend_q & ~low;
	assign is_last = none_q || (rest == '0);
	assign q_rd    = !q_empty && (!valid_q || (pop && is_last));
	assign empty   = !valid_q;

	always_comb begin
		msg_kind      = MSG_NONE;
		note_number   = '0;
		note_velocity = '0;
		if (!none_q) begin
			if (low[NUM_STEPS]) begin
				msg_kind      = MSG_ON;
				note_number   = cur_q.on_note;
				note_velocity = cur_q.on_vel;
			end
			for (int i = 0; i < NUM_STEPS; i++) begin
				if (low[i]) begin
					msg_kind      = MSG_OFF;
					note_number   = cur_q.off_note[i];
					note_velocity = cur_q.off_vel[i];
				end
			end
		end
	end

	assign led_mask    = cur_q.leds;
	assign is_running  = cur_q.run;
	assign last_result = is_last;

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= '0;
			none_q  <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			pend_q  <= {q_rec.on_flag, q_rec.off_mask};
			none_q  <= ({q_rec.on_flag, q_rec.off_mask} == '0);
		end else if (pop && valid_q) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				pend_q <= rest;
			end
		end
	end

endmodule

FILE: rtl/core/four_step_note_sequencer.sv
// ----------------------------------------------------------------------------
// four_step_note_sequencer
// Four-step note sequencer: ticks and button presses in, note messages out.
//
//   channel  handshake          payload
//   input    push / full        cmd, step_button
//   result   empty / pop        msg_kind, note_number, note_velocity,
//                               led_mask, is_running, last_result
//   config   cfg_valid/ready    cfg_index, cfg_data
//
// the front classifies an item in its accept cycle and queues one record
// the back sends one to five results, one per pop, from the record
// a two-entry record queue lets input run ahead while results stall
// full rises when both queue entries wait while the back is still draining
// knob writes act on next item; reset: slowest tempo, lowest note, else zero
// ----------------------------------------------------------------------------
module four_step_note_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [1:0] step_button,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] msg_kind,
	output logic [6:0] note_number,
	output logic [6:0] note_velocity,
	output logic [4:0] led_mask,
	output logic       is_running,
	output logic       last_result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import fsq_pkg::*;

	rec_t front_rec;
	rec_t q_rec;
	logic q_full;
	logic q_empty;
	logic q_rd;
	logic take;

	assign cfg_ready = 1'b1;
	assign full      = q_full;
	assign take      = push && !q_full;

	fsq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.cmd         (cmd),
		.step_button (step_button),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rec         (front_rec)
	);

	fsq_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (take),
		.wr_rec  (front_rec),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_rec  (q_rec),
		.q_empty (q_empty)
	);

	fsq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_rec         (q_rec),
		.q_empty       (q_empty),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.msg_kind      (msg_kind),
		.note_number   (note_number),
		.note_velocity (note_velocity),
		.led_mask      (led_mask),
		.is_running    (is_running),
		.last_result   (last_result)
	);

endmodule
